// ===== design/vmdl_pkg.sv =====
// Shared types and constants for the vertex morph and diffuse light core.
// Used by the shading front, the root step and the top level; no dependencies.
package vmdl_pkg;

  localparam int PosW  = 24;
  localparam int NrmW  = 16;
  localparam int FracW = 17;
  localparam int DW    = 25;
  localparam int DdW   = 51;
  localparam int NW    = 50;
  localparam int HalfW = 25;
  localparam int RW    = 68;
  localparam int PW    = 59;
  localparam int TW    = 100;
  localparam int ResW  = 8;

  typedef enum logic [2:0] {
    CFG_FRAC    = 3'd0,
    CFG_LIGHT_X = 3'd1,
    CFG_LIGHT_Y = 3'd2,
    CFG_LIGHT_Z = 3'd3,
    CFG_LIGHT_EN = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic            kill;
    logic [RW-1:0]   r;
    logic [PW-1:0]   p;
    logic [DdW-1:0]  dd;
    logic [TW-1:0]   t;
    logic [ResW-1:0] res;
  } vmdl_sq_t;

endpackage

// ===== design/vertex_morph_and_diffuse_light_core.sv =====
// Vertex keyframe morph with diffuse vertex lighting, top level.
// Depends on vmdl_pkg, vmdl_lerp, vmdl_shade_front and vmdl_root_step.
//
// One vertex word is taken on every clock at which start_i is high; busy_o
// stays low. Each result appears with done_o for one cycle once its word has
// passed two blend stages, five shading stages and one stage per bit of the
// eight-bit brightness root search. The receiver cannot stall.
module vertex_morph_and_diffuse_light_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [23:0]                       cfg_data_i,
  input  logic signed [vmdl_pkg::PosW-1:0]  first_pos_x_i,
  input  logic signed [vmdl_pkg::PosW-1:0]  first_pos_y_i,
  input  logic signed [vmdl_pkg::PosW-1:0]  first_pos_z_i,
  input  logic signed [vmdl_pkg::NrmW-1:0]  first_norm_x_i,
  input  logic signed [vmdl_pkg::NrmW-1:0]  first_norm_y_i,
  input  logic signed [vmdl_pkg::NrmW-1:0]  first_norm_z_i,
  input  logic signed [vmdl_pkg::PosW-1:0]  second_pos_x_i,
  input  logic signed [vmdl_pkg::PosW-1:0]  second_pos_y_i,
  input  logic signed [vmdl_pkg::PosW-1:0]  second_pos_z_i,
  input  logic signed [vmdl_pkg::NrmW-1:0]  second_norm_x_i,
  input  logic signed [vmdl_pkg::NrmW-1:0]  second_norm_y_i,
  input  logic signed [vmdl_pkg::NrmW-1:0]  second_norm_z_i,
  output logic                              done_o,
  output logic signed [vmdl_pkg::PosW-1:0]  out_pos_x_o,
  output logic signed [vmdl_pkg::PosW-1:0]  out_pos_y_o,
  output logic signed [vmdl_pkg::PosW-1:0]  out_pos_z_o,
  output logic signed [vmdl_pkg::NrmW-1:0]  out_norm_x_o,
  output logic signed [vmdl_pkg::NrmW-1:0]  out_norm_y_o,
  output logic signed [vmdl_pkg::NrmW-1:0]  out_norm_z_o,
  output logic [vmdl_pkg::ResW-1:0]         brightness_o
);

  localparam int Lat   = 15;
  localparam int Delay = 13;
  localparam logic [vmdl_pkg::FracW-1:0] One = vmdl_pkg::FracW'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [vmdl_pkg::PosW-1:0] px, py, pz;
    logic signed [vmdl_pkg::NrmW-1:0] nx, ny, nz;
  } vmdl_vtx_t;

  logic [vmdl_pkg::FracW-1:0]       frac_q, f_sat;
  logic signed [vmdl_pkg::PosW-1:0] light_q [3];
  logic                             light_on_q;
  logic [Lat-1:0]                   vld_q;
  logic signed [vmdl_pkg::PosW-1:0] pos [3];
  logic signed [vmdl_pkg::NrmW-1:0] nrm [3];
  vmdl_vtx_t                        vtx_q [Delay];
  vmdl_pkg::vmdl_sq_t               sq [9];

  assign f_sat = (frac_q > One) ? One : frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q     <= '0;
      light_q[0] <= '0;
      light_q[1] <= '0;
      light_q[2] <= '0;
      light_on_q <= 1'b1;
      vld_q      <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i};
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vmdl_pkg::CFG_FRAC:     frac_q     <= cfg_data_i[vmdl_pkg::FracW-1:0];
          vmdl_pkg::CFG_LIGHT_X:  light_q[0] <= $signed(cfg_data_i);
          vmdl_pkg::CFG_LIGHT_Y:  light_q[1] <= $signed(cfg_data_i);
          vmdl_pkg::CFG_LIGHT_Z:  light_q[2] <= $signed(cfg_data_i);
          vmdl_pkg::CFG_LIGHT_EN: light_on_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  vmdl_lerp #(.W(vmdl_pkg::PosW), .FRAC_BITS(FRAC_BITS)) u_lerp_px (
    .clk_i, .a_i(first_pos_x_i), .b_i(second_pos_x_i), .f_i(f_sat), .y_o(pos[0]));
  vmdl_lerp #(.W(vmdl_pkg::PosW), .FRAC_BITS(FRAC_BITS)) u_lerp_py (
    .clk_i, .a_i(first_pos_y_i), .b_i(second_pos_y_i), .f_i(f_sat), .y_o(pos[1]));
  vmdl_lerp #(.W(vmdl_pkg::PosW), .FRAC_BITS(FRAC_BITS)) u_lerp_pz (
    .clk_i, .a_i(first_pos_z_i), .b_i(second_pos_z_i), .f_i(f_sat), .y_o(pos[2]));
  vmdl_lerp #(.W(vmdl_pkg::NrmW), .FRAC_BITS(FRAC_BITS)) u_lerp_nx (
    .clk_i, .a_i(first_norm_x_i), .b_i(second_norm_x_i), .f_i(f_sat), .y_o(nrm[0]));
  vmdl_lerp #(.W(vmdl_pkg::NrmW), .FRAC_BITS(FRAC_BITS)) u_lerp_ny (
    .clk_i, .a_i(first_norm_y_i), .b_i(second_norm_y_i), .f_i(f_sat), .y_o(nrm[1]));
  vmdl_lerp #(.W(vmdl_pkg::NrmW), .FRAC_BITS(FRAC_BITS)) u_lerp_nz (
    .clk_i, .a_i(first_norm_z_i), .b_i(second_norm_z_i), .f_i(f_sat), .y_o(nrm[2]));

  vmdl_shade_front u_front (
    .clk_i,
    .pos_i      (pos),
    .nrm_i      (nrm),
    .light_i    (light_q),
    .light_on_i (light_on_q),
    .sq_o       (sq[0])
  );

  for (genvar k = 0; k < 8; k++) begin : g_step
    vmdl_root_step #(.BIT(7 - k)) u_step (
      .clk_i,
      .sq_i (sq[k]),
      .sq_o (sq[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    vtx_q[0] <= '{px: pos[0], py: pos[1], pz: pos[2],
                  nx: nrm[0], ny: nrm[1], nz: nrm[2]};
    for (int i = 1; i < Delay; i++) begin
      vtx_q[i] <= vtx_q[i-1];
    end
  end

  assign busy_o       = 1'b0;
  assign done_o       = vld_q[Lat-1];
  assign out_pos_x_o  = vtx_q[Delay-1].px;
  assign out_pos_y_o  = vtx_q[Delay-1].py;
  assign out_pos_z_o  = vtx_q[Delay-1].pz;
  assign out_norm_x_o = vtx_q[Delay-1].nx;
  assign out_norm_y_o = vtx_q[Delay-1].ny;
  assign out_norm_z_o = vtx_q[Delay-1].nz;
  assign brightness_o = sq[8].kill ? '0 : sq[8].res;

endmodule

// ===== design/vmdl_lerp.sv =====
// Two-stage keyframe blend of one component: a + (b - a) * f, rounded.
// No package dependency.
module vmdl_lerp #(
  parameter int W         = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  input  logic        [16:0]  f_i,
  output logic signed [W-1:0] y_o
);

  localparam int PrW = W + 19;
  localparam int AW  = PrW + 1;
  localparam logic signed [AW-1:0] Half = AW'(1) <<< (FRAC_BITS - 1);

  logic signed [W:0]     diff;
  logic signed [PrW-1:0] prod_d, prod_q;
  logic signed [W-1:0]   a_q, y_q;
  logic signed [AW-1:0]  acc;

  assign diff   = $signed({b_i[W-1], b_i}) - $signed({a_i[W-1], a_i});
  assign prod_d = PrW'(diff) * PrW'($signed({1'b0, f_i}));
  assign acc    = (AW'(a_q) <<< FRAC_BITS) + AW'(prod_q) + Half;

  always_ff @(posedge clk_i) begin
    a_q    <= a_i;
    prod_q <= prod_d;
    y_q    <= W'(acc >>> FRAC_BITS);
  end

  assign y_o = y_q;

endmodule

// ===== design/vmdl_shade_front.sv =====
// Shading front: light vector, dot products, and squared scaled dot product.
// Depends on vmdl_pkg; five register stages.
module vmdl_shade_front (
  input  logic                              clk_i,
  input  logic signed [vmdl_pkg::PosW-1:0]  pos_i [3],
  input  logic signed [vmdl_pkg::NrmW-1:0]  nrm_i [3],
  input  logic signed [vmdl_pkg::PosW-1:0]  light_i [3],
  input  logic                              light_on_i,
  output vmdl_pkg::vmdl_sq_t                sq_o
);

  localparam int NdPW = 41;
  localparam int NdW  = 43;
  localparam int SqW  = 50;

  logic signed [vmdl_pkg::DW-1:0]   d_q [3];
  logic signed [vmdl_pkg::NrmW-1:0] nrm_q [3];
  logic signed [NdPW-1:0]           ndp_q [3];
  logic signed [SqW-1:0]            dsq_q [3];
  logic signed [NdW-1:0]            nd;
  logic        [vmdl_pkg::DdW-1:0]  dd, dd5_q, dd6_q;
  logic                             kill, kill5_q, kill6_q;
  logic        [vmdl_pkg::NW-1:0]   n_q;
  logic        [vmdl_pkg::HalfW-1:0] nh, nl;
  logic        [2*vmdl_pkg::HalfW-1:0] hh_q, hl_q, ll_q;
  vmdl_pkg::vmdl_sq_t               sq_q;

  assign nd = NdW'(ndp_q[0]) + NdW'(ndp_q[1]) + NdW'(ndp_q[2]);
  assign dd = vmdl_pkg::DdW'(dsq_q[0]) + vmdl_pkg::DdW'(dsq_q[1])
            + vmdl_pkg::DdW'(dsq_q[2]);
  assign kill = (dd == '0) || (nd <= 0) || !light_on_i;
  assign nh = n_q[vmdl_pkg::NW-1:vmdl_pkg::HalfW];
  assign nl = n_q[vmdl_pkg::HalfW-1:0];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d_q[i]   <= vmdl_pkg::DW'(light_i[i]) - vmdl_pkg::DW'(pos_i[i]);
      nrm_q[i] <= nrm_i[i];
      ndp_q[i] <= NdPW'(nrm_q[i]) * NdPW'(d_q[i]);
      dsq_q[i] <= SqW'(d_q[i]) * SqW'(d_q[i]);
    end
    dd5_q   <= dd;
    kill5_q <= kill;
    n_q     <= kill ? '0 : (vmdl_pkg::NW'(nd) << 8) - vmdl_pkg::NW'(nd);
    hh_q    <= (2*vmdl_pkg::HalfW)'(nh) * (2*vmdl_pkg::HalfW)'(nh);
    hl_q    <= (2*vmdl_pkg::HalfW)'(nh) * (2*vmdl_pkg::HalfW)'(nl);
    ll_q    <= (2*vmdl_pkg::HalfW)'(nl) * (2*vmdl_pkg::HalfW)'(nl);
    dd6_q   <= dd5_q;
    kill6_q <= kill5_q;
    sq_q.kill <= kill6_q;
    sq_q.r    <= '0;
    sq_q.p    <= '0;
    sq_q.res  <= '0;
    sq_q.dd   <= dd6_q;
    sq_q.t    <= (vmdl_pkg::TW'(hh_q) << (2*vmdl_pkg::HalfW))
               + (vmdl_pkg::TW'(hl_q) << (vmdl_pkg::HalfW + 1))
               + vmdl_pkg::TW'(ll_q);
  end

  assign sq_o = sq_q;

endmodule

// ===== design/vmdl_root_step.sv =====
// One bit of the brightness root search: try res | 1<<BIT against the target.
// Depends on vmdl_pkg; one register stage.
module vmdl_root_step #(
  parameter int BIT = 7
) (
  input  logic               clk_i,
  input  vmdl_pkg::vmdl_sq_t sq_i,
  output vmdl_pkg::vmdl_sq_t sq_o
);

  logic [vmdl_pkg::RW-1:0] cand;
  logic                    fits;
  vmdl_pkg::vmdl_sq_t      sq_d, sq_q;

  assign cand = sq_i.r + (vmdl_pkg::RW'(sq_i.p) << (BIT + 1))
              + (vmdl_pkg::RW'(sq_i.dd) << (2 * BIT));
  assign fits = (vmdl_pkg::TW'(cand) << 28) <= sq_i.t;

  always_comb begin
    sq_d = sq_i;
    if (fits) begin
      sq_d.r   = cand;
      sq_d.p   = sq_i.p + (vmdl_pkg::PW'(sq_i.dd) << BIT);
      sq_d.res = sq_i.res | vmdl_pkg::ResW'(1 << BIT);
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

// ===== test/vertex_morph_and_diffuse_light_core_chk.sv =====
`timescale 1ns / 100ps
// Checker for the vertex morph and diffuse light core: mirrors the registers, predicts
// every vertex word and compares each result strobe. Depends on vmdl_pkg.
module vertex_morph_and_diffuse_light_core_chk (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_idx_i,
  input  logic [23:0]                      cfg_data_i,
  input  logic signed [vmdl_pkg::PosW-1:0] first_pos_i [3],
  input  logic signed [vmdl_pkg::NrmW-1:0] first_norm_i [3],
  input  logic signed [vmdl_pkg::PosW-1:0] second_pos_i [3],
  input  logic signed [vmdl_pkg::NrmW-1:0] second_norm_i [3],
  input  logic                             done_i,
  input  logic signed [vmdl_pkg::PosW-1:0] out_pos_i [3],
  input  logic signed [vmdl_pkg::NrmW-1:0] out_norm_i [3],
  input  logic [vmdl_pkg::ResW-1:0]        brightness_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  typedef struct {
    logic signed [vmdl_pkg::PosW-1:0] pos [3];
    logic signed [vmdl_pkg::NrmW-1:0] nrm [3];
    logic [vmdl_pkg::ResW-1:0]        lum;
  } lit_vertex_t;

  lit_vertex_t     lit_q[$];
  logic [vmdl_pkg::FracW-1:0] frac_r;
  longint          light_r [3];
  logic            light_en_r;
  int              fails;

  assign fail_count_o = fails;
  assign pending_o    = lit_q.size();

  function automatic longint lerp(longint a, longint b, longint f);
    return (a * (65536 - f) + b * f + 32768) >>> 16;
  endfunction

  function automatic logic [vmdl_pkg::ResW-1:0] lambert(longint p [3], longint n [3]);
    longint d, nd, dd;
    logic [127:0] t, c, m, b;
    logic [vmdl_pkg::ResW-1:0] r;
    nd = 0;
    dd = 0;
    r  = '0;
    for (int i = 0; i < 3; i++) begin
      d  = light_r[i] - p[i];
      nd += n[i] * d;
      dd += d * d;
    end
    if (dd == 0 || nd <= 0) return '0;
    m = nd * 255;
    t = m * m;
    for (int k = 7; k >= 0; k--) begin
      b = {r} | (128'd1 << k);
      c = ((b * b) << 28) * dd;
      if (c <= t) r = b[vmdl_pkg::ResW-1:0];
    end
    return r;
  endfunction

  function automatic lit_vertex_t predict_vertex();
    lit_vertex_t v;
    longint f, p [3], n [3];
    f = (frac_r > 17'd65536) ? 65536 : longint'(frac_r);
    for (int i = 0; i < 3; i++) begin
      p[i] = lerp(first_pos_i[i], second_pos_i[i], f);
      n[i] = lerp(first_norm_i[i], second_norm_i[i], f);
      v.pos[i] = vmdl_pkg::PosW'(p[i]);
      v.nrm[i] = vmdl_pkg::NrmW'(n[i]);
    end
    v.lum = light_en_r ? lambert(p, n) : '0;
    return v;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      fails++;
      if (fails <= 10)
        $display("mismatch %s: expected %0d got %0d at %0t", name, exp_v, act_v, $realtime);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lit_vertex_t e;
    if (!rst_ni) begin
      frac_r     <= '0;
      light_r    <= '{0, 0, 0};
      light_en_r <= 1'b1;
      fails      = 0;
      lit_q.delete();
    end else begin
      if (done_i) begin
        if (lit_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result word with nothing expected at %0t", $realtime);
        end else begin
          e = lit_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            check_field($sformatf("out_pos[%0d]", i), e.pos[i], out_pos_i[i]);
            check_field($sformatf("out_norm[%0d]", i), e.nrm[i], out_norm_i[i]);
          end
          check_field("brightness", e.lum, brightness_i);
        end
      end
      if (start_i && !busy_i) lit_q.push_back(predict_vertex());
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vmdl_pkg::CFG_FRAC:     frac_r     <= cfg_data_i[vmdl_pkg::FracW-1:0];
          vmdl_pkg::CFG_LIGHT_X:  light_r[0] <= longint'($signed(cfg_data_i));
          vmdl_pkg::CFG_LIGHT_Y:  light_r[1] <= longint'($signed(cfg_data_i));
          vmdl_pkg::CFG_LIGHT_Z:  light_r[2] <= longint'($signed(cfg_data_i));
          vmdl_pkg::CFG_LIGHT_EN: light_en_r <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== test/vertex_morph_and_diffuse_light_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the vertex morph and diffuse light core: drives vertex words and
// register writes, gives the verdict. Depends on vmdl_pkg, the core top level and the checker module.
module vertex_morph_and_diffuse_light_core_tb;

  localparam int CycleLimit = 400000;

  logic clk, rst_n, start, busy, cfg_we, done;
  logic [2:0]  cfg_idx;
  logic [23:0] cfg_data;
  logic signed [vmdl_pkg::PosW-1:0] fpos [3], spos [3], opos [3];
  logic signed [vmdl_pkg::NrmW-1:0] fnrm [3], snrm [3], onrm [3];
  logic [vmdl_pkg::ResW-1:0] lum;
  int fails, pending, cycles;

  vertex_morph_and_diffuse_light_core u_top (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .first_pos_x_i(fpos[0]), .first_pos_y_i(fpos[1]), .first_pos_z_i(fpos[2]),
    .first_norm_x_i(fnrm[0]), .first_norm_y_i(fnrm[1]), .first_norm_z_i(fnrm[2]),
    .second_pos_x_i(spos[0]), .second_pos_y_i(spos[1]), .second_pos_z_i(spos[2]),
    .second_norm_x_i(snrm[0]), .second_norm_y_i(snrm[1]), .second_norm_z_i(snrm[2]),
    .done_o(done),
    .out_pos_x_o(opos[0]), .out_pos_y_o(opos[1]), .out_pos_z_o(opos[2]),
    .out_norm_x_o(onrm[0]), .out_norm_y_o(onrm[1]), .out_norm_z_o(onrm[2]),
    .brightness_o(lum)
  );

  vertex_morph_and_diffuse_light_core_chk u_chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .first_pos_i(fpos), .first_norm_i(fnrm), .second_pos_i(spos), .second_norm_i(snrm),
    .done_i(done), .out_pos_i(opos), .out_norm_i(onrm), .brightness_i(lum),
    .fail_count_o(fails), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [23:0] pick_pos();
    case ($urandom_range(0, 5))
      0:       return 24'h7fffff;
      1:       return 24'h800000;
      2, 3:    return 24'($urandom_range(0, 8192)) - 24'd4096;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_norm();
    case ($urandom_range(0, 5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(0, 32768)) - 16'd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(vmdl_pkg::cfg_idx_e idx, logic [23:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_word(logic [23:0] p0 [3], logic [15:0] n0 [3],
                           logic [23:0] p1 [3], logic [15:0] n1 [3], int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      fpos[i] <= p0[i];
      fnrm[i] <= n0[i];
      spos[i] <= p1[i];
      snrm[i] <= n1[i];
    end
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic [23:0] p0 [3], p1 [3];
    logic [15:0] n0 [3], n1 [3];
    int gap;
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 3; i++) begin
        p0[i] = pick_pos();
        p1[i] = pick_pos();
        n0[i] = pick_norm();
        n1[i] = pick_norm();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if ((k / 40) % 3 == 0) gap = 0;
      send_word(p0, n0, p1, n1, gap);
    end
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic set_light(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    write_reg(vmdl_pkg::CFG_LIGHT_X, x);
    write_reg(vmdl_pkg::CFG_LIGHT_Y, y);
    write_reg(vmdl_pkg::CFG_LIGHT_Z, z);
  endtask

  initial begin
    logic [23:0] zp [3], mxp [3], mnp [3], ap [3];
    logic [15:0] zn [3], mxn [3], mnn [3], un [3], dn [3];
    cycles   = 0;
    rst_n    = 1'b0;
    start    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = vmdl_pkg::CFG_FRAC;
    cfg_data = '0;
    fpos = '{0, 0, 0};
    spos = '{0, 0, 0};
    fnrm = '{0, 0, 0};
    snrm = '{0, 0, 0};
    zp  = '{0, 0, 0};
    mxp = '{24'h7fffff, 24'h7fffff, 24'h7fffff};
    mnp = '{24'h800000, 24'h800000, 24'h800000};
    ap  = '{24'h000100, 24'hfffe00, 24'h000000};
    zn  = '{0, 0, 0};
    mxn = '{16'h7fff, 16'h7fff, 16'h7fff};
    mnn = '{16'h8000, 16'h8000, 16'h8000};
    un  = '{16'h0000, 16'h0000, 16'h4000};
    dn  = '{16'h0000, 16'h0000, 16'hc000};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: copy case, light at origin
    send_word(zp, un, mxp, mxn, 0);
    send_word(mxp, mxn, mnp, mnn, 0);
    send_word(mnp, mnn, mxp, mxn, 1);
    send_word(ap, un, zp, zn, 0);
    send_word(ap, dn, ap, dn, 2);
    send_word(mxp, mnn, zp, zn, 0);
    drain();

    set_light(24'h000000, 24'h000000, 24'h001000);
    write_reg(vmdl_pkg::CFG_FRAC, 24'd32768);
    send_word(zp, un, zp, un, 0);
    send_word(zp, dn, zp, dn, 0);
    send_word(mxp, mxn, mnp, mnn, 0);
    send_word(ap, un, mnp, mxn, 3);
    drain();
    write_reg(vmdl_pkg::CFG_FRAC, 24'd65536);
    send_word(zp, zn, ap, un, 0);
    send_word(mnp, mnn, mxp, mxn, 0);
    drain();
    write_reg(vmdl_pkg::CFG_FRAC, 24'h1ffff);
    send_word(mxp, mxn, zp, un, 0);
    send_word(zp, zn, mnp, mnn, 0);
    drain();
    write_reg(vmdl_pkg::CFG_LIGHT_EN, 24'd0);
    send_word(zp, un, zp, un, 0);
    send_word(ap, mxn, mxp, mxn, 0);
    drain();

    write_reg(vmdl_pkg::CFG_LIGHT_EN, 24'd1);
    write_reg(vmdl_pkg::CFG_FRAC, 24'd0);
    send_random(250);
    drain();
    set_light(24'h7fffff, 24'h7fffff, 24'h7fffff);
    write_reg(vmdl_pkg::CFG_FRAC, 24'd65536);
    send_random(250);
    drain();
    set_light(24'h800000, 24'h800000, 24'h800000);
    write_reg(vmdl_pkg::CFG_FRAC, 24'd1);
    send_random(250);
    drain();
    set_light(24'h000400, 24'hfff000, 24'h000800);
    write_reg(vmdl_pkg::CFG_FRAC, 24'(65537 + $urandom_range(0, 65534)));
    send_random(200);
    drain();
    write_reg(vmdl_pkg::CFG_LIGHT_EN, 24'd0);
    write_reg(vmdl_pkg::CFG_FRAC, 24'($urandom_range(0, 65536)));
    send_random(200);
    drain();
    write_reg(vmdl_pkg::CFG_LIGHT_EN, 24'd1);
    for (int ph = 0; ph < 4; ph++) begin
      set_light(24'($urandom), 24'($urandom_range(0, 8192)) - 24'd4096, 24'($urandom));
      write_reg(vmdl_pkg::CFG_FRAC, 24'($urandom_range(0, 65536)));
      send_random(140);
      drain();
    end

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
